// ----- src/drtps_pkg.sv -----
package drtps_pkg;

  localparam int DIM_W      = 13;
  localparam int PAGE_W     = 16;
  localparam int THR_W      = 9;
  localparam int PIX_W      = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int PROD_W     = DIM_W + PAGE_W;
  localparam int STEP_W     = $clog2(PAGE_W);
  localparam int Q_DEPTH    = 4;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);
  localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_IMAGE_WIDTH    = cfg_idx_t'(0);
  localparam cfg_idx_t CFG_IMAGE_HEIGHT   = cfg_idx_t'(1);
  localparam cfg_idx_t CFG_PAGE_WIDTH     = cfg_idx_t'(2);
  localparam cfg_idx_t CFG_PAGE_HEIGHT    = cfg_idx_t'(3);
  localparam cfg_idx_t CFG_DARK_THRESHOLD = cfg_idx_t'(4);

  localparam logic [DIM_W-1:0]  RST_IMAGE_WIDTH    = DIM_W'(256);
  localparam logic [DIM_W-1:0]  RST_IMAGE_HEIGHT   = DIM_W'(256);
  localparam logic [PAGE_W-1:0] RST_PAGE_WIDTH     = PAGE_W'(950);
  localparam logic [PAGE_W-1:0] RST_PAGE_HEIGHT    = PAGE_W'(1485);
  localparam logic [THR_W-1:0]  RST_DARK_THRESHOLD = THR_W'(127);

  localparam logic CMD_PEN_DOWN = 1'b0;
  localparam logic CMD_PEN_UP   = 1'b1;

  localparam logic [STEP_W-1:0] STEP_LAST = '1;

  typedef struct packed {
    logic [DIM_W-1:0] img_w;
    logic [DIM_W-1:0] img_h;
  } dims_t;

  typedef struct packed {
    logic [PAGE_W-1:0] pw;
    logic [PAGE_W-1:0] ph;
  } page_t;

  typedef struct packed {
    logic             first_vld;
    logic             first_cmd;
    logic             close_vld;
    logic             origin_vld;
    logic [DIM_W-1:0] col;
    logic [DIM_W-1:0] rw;
  } entry_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MUL,
    BK_DIV,
    BK_EMIT
  } bk_state_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input int unsigned max_dim);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (32'(v) > max_dim) begin
      r = DIM_W'(max_dim);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ----- src/drtps_front.sv -----
module drtps_front #(
  parameter int CNT_W = 12
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [drtps_pkg::PIX_W-1:0]   in_lightness,
  input  drtps_pkg::dims_t              dims,
  input  logic [drtps_pkg::THR_W-1:0]   thr,
  input  logic                          q_full,
  output logic                          q_push,
  output drtps_pkg::entry_t             q_data
);

  logic [CNT_W-1:0] column_r, column_nxt;
  logic [CNT_W-1:0] row_r, row_nxt;
  logic             in_run_r, in_run_nxt;

  logic [drtps_pkg::DIM_W-1:0] w_last, h_last, col_ext, row_ext, col, rw;
  logic row_end, image_end, dark, accept;

  assign w_last  = dims.img_w - drtps_pkg::DIM_W'(1);
  assign h_last  = dims.img_h - drtps_pkg::DIM_W'(1);
  assign col_ext = drtps_pkg::DIM_W'(column_r);
  assign row_ext = drtps_pkg::DIM_W'(row_r);
  assign col     = (col_ext >= w_last) ? w_last : col_ext;
  assign rw      = (row_ext >= h_last) ? h_last : row_ext;

  assign row_end   = (col == w_last);
  assign image_end = row_end && (rw == h_last);
  assign dark      = ({1'b0, in_lightness} < thr);

  assign in_ready = !q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    q_data.first_vld  = dark ^ in_run_r;
    q_data.first_cmd  = dark ? drtps_pkg::CMD_PEN_DOWN : drtps_pkg::CMD_PEN_UP;
    q_data.close_vld  = row_end && dark;
    q_data.origin_vld = image_end;
    q_data.col        = col;
    q_data.rw         = rw;
  end

  assign q_push = accept &&
                  (q_data.first_vld || q_data.close_vld || q_data.origin_vld);

  always_comb begin
    in_run_nxt = dark && !row_end;
    if (image_end) begin
      column_nxt = '0;
      row_nxt    = '0;
    end else if (row_end) begin
      column_nxt = '0;
      row_nxt    = CNT_W'(rw + drtps_pkg::DIM_W'(1));
    end else begin
      column_nxt = CNT_W'(col + drtps_pkg::DIM_W'(1));
      row_nxt    = row_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r <= '0;
      row_r    <= '0;
      in_run_r <= 1'b0;
    end else if (accept) begin
      column_r <= column_nxt;
      row_r    <= row_nxt;
      in_run_r <= in_run_nxt;
    end
  end

endmodule

// ----- src/drtps_queue.sv -----
module drtps_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  drtps_pkg::entry_t push_data,
  output logic              full,
  input  logic              pop,
  output drtps_pkg::entry_t pop_data,
  output logic              empty
);

  drtps_pkg::entry_t mem_r [drtps_pkg::Q_DEPTH];

  logic [drtps_pkg::Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [drtps_pkg::Q_CNT_W-1:0] count_r;

  assign full     = (count_r == drtps_pkg::Q_CNT_W'(drtps_pkg::Q_DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + drtps_pkg::Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + drtps_pkg::Q_PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + drtps_pkg::Q_CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - drtps_pkg::Q_CNT_W'(1);
      end
    end
  end

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= drtps_pkg::Q_CNT_W'(drtps_pkg::Q_DEPTH))
    else $error("queue count beyond depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("word pushed into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("word popped from empty queue");

endmodule

// ----- src/drtps_back.sv -----
module drtps_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  drtps_pkg::dims_t             dims,
  input  drtps_pkg::page_t             page,
  input  logic                         q_empty,
  input  drtps_pkg::entry_t            q_data,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_command,
  output logic [drtps_pkg::PAGE_W-1:0] out_pos_x,
  output logic [drtps_pkg::PAGE_W-1:0] out_pos_y,
  output logic                         out_last
);

  drtps_pkg::bk_state_t state_r, state_nxt;

  logic pend_first_r, pend_close_r, pend_origin_r;
  logic first_cmd_r, phase_y_r;
  logic [drtps_pkg::DIM_W-1:0]  col_r, rw_r;
  logic [drtps_pkg::DIM_W-1:0]  rem_r;
  logic [drtps_pkg::PAGE_W-1:0] lo_r;
  logic [drtps_pkg::STEP_W-1:0] step_r;
  logic [drtps_pkg::PAGE_W-1:0] px_r, py_r;

  logic                         out_valid_r, out_command_r, out_last_r;
  logic [drtps_pkg::PAGE_W-1:0] out_pos_x_r, out_pos_y_r;

  logic cur_first, cur_origin;
  logic first_after, close_after, origin_after, last_val;
  logic out_free, load_out, div_done;
  logic [drtps_pkg::DIM_W-1:0]  xpos, mul_a, div_dim;
  logic [drtps_pkg::PAGE_W-1:0] mul_b;
  logic [drtps_pkg::PROD_W-1:0] prod;
  logic [drtps_pkg::DIM_W:0]    trial, diff;
  logic                         ge;
  logic [drtps_pkg::DIM_W-1:0]  rem_step;
  logic [drtps_pkg::PAGE_W-1:0] lo_step;

  assign cur_first  = pend_first_r;
  assign cur_origin = !pend_first_r && !pend_close_r;

  assign xpos    = cur_first ? col_r : dims.img_w;
  assign mul_a   = phase_y_r ? rw_r : xpos;
  assign mul_b   = phase_y_r ? page.ph : page.pw;
  assign prod    = drtps_pkg::PROD_W'(mul_a) * drtps_pkg::PROD_W'(mul_b);
  assign div_dim = phase_y_r ? dims.img_h : dims.img_w;

  // restoring division, one quotient bit per cycle
  assign trial    = {rem_r, lo_r[drtps_pkg::PAGE_W-1]};
  assign ge       = (trial >= {1'b0, div_dim});
  assign diff     = trial - {1'b0, div_dim};
  assign rem_step = ge ? diff[drtps_pkg::DIM_W-1:0] : trial[drtps_pkg::DIM_W-1:0];
  assign lo_step  = {lo_r[drtps_pkg::PAGE_W-2:0], ge};

  assign first_after  = 1'b0;
  assign close_after  = cur_first && pend_close_r;
  assign origin_after = !cur_origin && pend_origin_r;
  assign last_val     = !(first_after || close_after || origin_after);

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      drtps_pkg::BK_IDLE: begin
        if (!q_empty) begin
          if (q_data.first_vld || q_data.close_vld) begin
            state_nxt = drtps_pkg::BK_MUL;
          end else begin
            state_nxt = drtps_pkg::BK_EMIT;
          end
        end
      end
      drtps_pkg::BK_MUL: begin
        state_nxt = drtps_pkg::BK_DIV;
      end
      drtps_pkg::BK_DIV: begin
        if (step_r == drtps_pkg::STEP_LAST) begin
          state_nxt = phase_y_r ? drtps_pkg::BK_MUL : drtps_pkg::BK_EMIT;
        end
      end
      drtps_pkg::BK_EMIT: begin
        if (out_free) begin
          if (first_after || close_after) begin
            state_nxt = drtps_pkg::BK_MUL;
          end else if (origin_after) begin
            state_nxt = drtps_pkg::BK_EMIT;
          end else begin
            state_nxt = drtps_pkg::BK_IDLE;
          end
        end
      end
      default: begin
        state_nxt = drtps_pkg::BK_IDLE;
      end
    endcase
  end

  always_comb begin
    q_pop    = 1'b0;
    load_out = 1'b0;
    div_done = 1'b0;
    case (state_r)
      drtps_pkg::BK_IDLE: q_pop    = !q_empty;
      drtps_pkg::BK_DIV:  div_done = (step_r == drtps_pkg::STEP_LAST);
      drtps_pkg::BK_EMIT: load_out = out_free;
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= drtps_pkg::BK_IDLE;
      pend_first_r  <= 1'b0;
      pend_close_r  <= 1'b0;
      pend_origin_r <= 1'b0;
      phase_y_r     <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (q_pop) begin
        pend_first_r  <= q_data.first_vld;
        pend_close_r  <= q_data.close_vld;
        pend_origin_r <= q_data.origin_vld;
        phase_y_r     <= 1'b1;
      end else if (load_out) begin
        pend_first_r  <= first_after;
        pend_close_r  <= close_after;
        pend_origin_r <= origin_after;
      end
      if (div_done && phase_y_r) begin
        phase_y_r <= 1'b0;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      first_cmd_r <= q_data.first_cmd;
      col_r       <= q_data.col;
      rw_r        <= q_data.rw;
    end
    if (state_r == drtps_pkg::BK_MUL) begin
      rem_r  <= prod[drtps_pkg::PROD_W-1:drtps_pkg::PAGE_W];
      lo_r   <= prod[drtps_pkg::PAGE_W-1:0];
      step_r <= '0;
    end else if (state_r == drtps_pkg::BK_DIV) begin
      rem_r  <= rem_step;
      lo_r   <= lo_step;
      step_r <= step_r + drtps_pkg::STEP_W'(1);
    end
    if (div_done) begin
      if (phase_y_r) begin
        py_r <= lo_step;
      end else begin
        px_r <= lo_step;
      end
    end
    if (load_out) begin
      out_command_r <= cur_first ? first_cmd_r : drtps_pkg::CMD_PEN_UP;
      out_pos_x_r   <= cur_origin ? '0 : px_r;
      out_pos_y_r   <= cur_origin ? '0 : py_r;
      out_last_r    <= last_val;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_command = out_command_r;
  assign out_pos_x   = out_pos_x_r;
  assign out_pos_y   = out_pos_y_r;
  assign out_last    = out_last_r;

  a_rem_below_dim: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == drtps_pkg::BK_DIV) |-> (rem_r < div_dim))
    else $error("division remainder not below divisor");

  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == drtps_pkg::BK_IDLE) |-> !(pend_first_r || pend_close_r || pend_origin_r))
    else $error("idle with results still pending");

  a_not_last_keeps_work: assert property (@(posedge clk) disable iff (!rst_n)
    (load_out && !last_val) |=> (pend_close_r || pend_origin_r))
    else $error("word marked not last but nothing follows");

endmodule

// ----- src/dark_run_to_plotter_strokes.sv -----
// stroke words: a pixel that opens or closes a stroke is queued; an idle back end pops it,
// multiplies and divides for y, then for x, and registers the first word; a second stroke word
// redoes only the x division, and the origin word is loaded straight after the one before it
// throughput: one pixel per cycle while the 4-entry queue has room; the back end handles one
// queued pixel at a time and pops the next only once it is idle again
// reset: synchronous active-low rst_n clears counters, run flag, queue, back end, loads defaults
module dark_run_to_plotter_strokes #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [drtps_pkg::PIX_W-1:0]      in_lightness,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_command,
  output logic [drtps_pkg::PAGE_W-1:0]     out_pos_x,
  output logic [drtps_pkg::PAGE_W-1:0]     out_pos_y,
  output logic                             out_last,
  input  logic                             cfg_we,
  input  drtps_pkg::cfg_idx_t              cfg_index,
  input  logic [drtps_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int CNT_W = (MAX_DIM > (1 << drtps_pkg::DIM_W)) ? drtps_pkg::DIM_W
                                                           : $clog2(MAX_DIM);

  logic [drtps_pkg::DIM_W-1:0]  img_w_r, img_h_r;
  logic [drtps_pkg::PAGE_W-1:0] page_w_r, page_h_r;
  logic [drtps_pkg::THR_W-1:0]  thr_r;

  drtps_pkg::dims_t  dims;
  drtps_pkg::page_t  page;
  drtps_pkg::entry_t push_data, pop_data;
  logic q_push, q_full, q_pop, q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r  <= drtps_pkg::RST_IMAGE_WIDTH;
      img_h_r  <= drtps_pkg::RST_IMAGE_HEIGHT;
      page_w_r <= drtps_pkg::RST_PAGE_WIDTH;
      page_h_r <= drtps_pkg::RST_PAGE_HEIGHT;
      thr_r    <= drtps_pkg::RST_DARK_THRESHOLD;
    end else if (cfg_we) begin
      case (cfg_index)
        drtps_pkg::CFG_IMAGE_WIDTH:    img_w_r  <= cfg_data[drtps_pkg::DIM_W-1:0];
        drtps_pkg::CFG_IMAGE_HEIGHT:   img_h_r  <= cfg_data[drtps_pkg::DIM_W-1:0];
        drtps_pkg::CFG_PAGE_WIDTH:     page_w_r <= cfg_data;
        drtps_pkg::CFG_PAGE_HEIGHT:    page_h_r <= cfg_data;
        drtps_pkg::CFG_DARK_THRESHOLD: thr_r    <= cfg_data[drtps_pkg::THR_W-1:0];
        default: begin
          thr_r <= thr_r;
        end
      endcase
    end
  end

  assign dims.img_w = drtps_pkg::clamp_dim(img_w_r, MAX_DIM);
  assign dims.img_h = drtps_pkg::clamp_dim(img_h_r, MAX_DIM);
  assign page.pw    = page_w_r;
  assign page.ph    = page_h_r;

  drtps_front #(
    .CNT_W (CNT_W)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_lightness (in_lightness),
    .dims         (dims),
    .thr          (thr_r),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_data       (push_data)
  );

  drtps_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (pop_data),
    .empty     (q_empty)
  );

  drtps_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .dims        (dims),
    .page        (page),
    .q_empty     (q_empty),
    .q_data      (pop_data),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_command (out_command),
    .out_pos_x   (out_pos_x),
    .out_pos_y   (out_pos_y),
    .out_last    (out_last)
  );

endmodule

// ----- tb/dark_run_to_plotter_strokes_tb.sv -----
`timescale 1ns / 100ps

module dark_run_to_plotter_strokes_tb;

  localparam int unsigned DIM_LIMIT = 4096;
  localparam int SETTLE = 150;
  localparam int HOLD_CYCLES = 600;
  localparam int LIMIT = 400000;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 40;

  localparam drtps_pkg::cfg_idx_t CFG_SPARE_5 = drtps_pkg::cfg_idx_t'(5);
  localparam drtps_pkg::cfg_idx_t CFG_SPARE_6 = drtps_pkg::cfg_idx_t'(6);
  localparam drtps_pkg::cfg_idx_t CFG_SPARE_7 = drtps_pkg::cfg_idx_t'(7);

  typedef struct packed {
    logic                         cmd;
    logic [drtps_pkg::PAGE_W-1:0] x;
    logic [drtps_pkg::PAGE_W-1:0] y;
    logic                         last;
  } stroke_pt_t;

  localparam stroke_pt_t NO_PT = '0;

  typedef enum logic {ROW_CFG, ROW_PIXEL} row_kind_t;

  typedef struct {
    row_kind_t                        kind;
    drtps_pkg::cfg_idx_t              idx;
    logic [drtps_pkg::CFG_DATA_W-1:0] data;
    logic [drtps_pkg::PIX_W-1:0]      lightness;
    bit                               typed;
    int                               n;
    stroke_pt_t                       pts[3];
  } stim_row_t;

  logic                             clk;
  logic                             rst_n;
  logic                             in_valid;
  logic                             in_ready;
  logic [drtps_pkg::PIX_W-1:0]      in_lightness;
  logic                             out_valid;
  logic                             out_ready;
  logic                             out_command;
  logic [drtps_pkg::PAGE_W-1:0]     out_pos_x;
  logic [drtps_pkg::PAGE_W-1:0]     out_pos_y;
  logic                             out_last;
  logic                             cfg_we;
  drtps_pkg::cfg_idx_t              cfg_index;
  logic [drtps_pkg::CFG_DATA_W-1:0] cfg_data;

  logic [drtps_pkg::DIM_W-1:0]  img_w_reg;
  logic [drtps_pkg::DIM_W-1:0]  img_h_reg;
  logic [drtps_pkg::PAGE_W-1:0] page_w_reg;
  logic [drtps_pkg::PAGE_W-1:0] page_h_reg;
  logic [drtps_pkg::THR_W-1:0]  thr_reg;
  int unsigned                  cur_col;
  int unsigned                  cur_row;
  bit                           in_stroke;

  stroke_pt_t pending_points[$];
  stim_row_t  dir_rows[$];
  int         mismatches = 0;
  int         cycle_count = 0;
  int         send_calm = 0;
  int         recv_calm = 0;
  int         recv_wait = 0;
  bit         hold_req = 0;
  bit         quiet = 1;

  dark_run_to_plotter_strokes uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_lightness (in_lightness),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_command  (out_command),
    .out_pos_x    (out_pos_x),
    .out_pos_y    (out_pos_y),
    .out_last     (out_last),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("FAIL dark_run_to_plotter_strokes");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    if (mismatches < 100) begin
      $display("ERROR %0t: %s", $realtime, msg);
    end
    mismatches++;
  endtask

  // mostly random waits, with occasional runs of back-to-back words
  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(10, 30);
      return 0;
    end
    return $urandom_range(0, 13);
  endfunction

  function automatic stroke_pt_t pt(input logic c, input int unsigned x, input int unsigned y,
                                    input logic l);
    stroke_pt_t p;
    p.cmd  = c;
    p.x    = drtps_pkg::PAGE_W'(x);
    p.y    = drtps_pkg::PAGE_W'(y);
    p.last = l;
    return p;
  endfunction

  function automatic int unsigned eff_dim(input logic [drtps_pkg::DIM_W-1:0] v);
    if (v == '0) return 1;
    if (32'(v) > DIM_LIMIT) return DIM_LIMIT;
    return 32'(v);
  endfunction

  function automatic logic [drtps_pkg::PAGE_W-1:0] page_pos(input int unsigned idx,
                                                            input int unsigned pg,
                                                            input int unsigned dim);
    longint unsigned p;
    p = 64'(idx);
    p = p * 64'(pg) / 64'(dim);
    return p[drtps_pkg::PAGE_W-1:0];
  endfunction

  function automatic void plot_pixel(input logic [drtps_pkg::PIX_W-1:0] l, input bit keep);
    stroke_pt_t                   pts[3];
    int                           n;
    int                           i;
    int unsigned                  w;
    int unsigned                  h;
    int unsigned                  c;
    int unsigned                  rw;
    logic [drtps_pkg::PAGE_W-1:0] py;
    bit                           row_end;
    bit                           img_end;
    bit                           dark;
    w = eff_dim(img_w_reg);
    h = eff_dim(img_h_reg);
    c = (cur_col < w - 1) ? cur_col : w - 1;
    rw = (cur_row < h - 1) ? cur_row : h - 1;
    row_end = (c == w - 1);
    img_end = row_end && (rw == h - 1);
    dark = (drtps_pkg::THR_W'(l) < thr_reg);
    py = page_pos(rw, 32'(page_h_reg), h);
    n = 0;
    if (dark && !in_stroke) begin
      pts[n] = pt(drtps_pkg::CMD_PEN_DOWN, 32'(page_pos(c, 32'(page_w_reg), w)), 32'(py), 1'b0);
      n++;
      in_stroke = 1;
    end else if (!dark && in_stroke) begin
      pts[n] = pt(drtps_pkg::CMD_PEN_UP, 32'(page_pos(c, 32'(page_w_reg), w)), 32'(py), 1'b0);
      n++;
      in_stroke = 0;
    end
    if (row_end && in_stroke) begin
      pts[n] = pt(drtps_pkg::CMD_PEN_UP, 32'(page_pos(w, 32'(page_w_reg), w)), 32'(py), 1'b0);
      n++;
      in_stroke = 0;
    end
    if (img_end) begin
      pts[n] = pt(drtps_pkg::CMD_PEN_UP, 0, 0, 1'b0);
      n++;
    end
    if (n > 0) pts[n-1].last = 1'b1;
    if (img_end) begin
      cur_col = 0;
      cur_row = 0;
      in_stroke = 0;
    end else if (row_end) begin
      cur_col = 0;
      cur_row = rw + 1;
    end else begin
      cur_col = c + 1;
    end
    if (keep) begin
      for (i = 0; i < n; i++) pending_points.push_back(pts[i]);
    end
  endfunction

  function automatic logic [drtps_pkg::PIX_W-1:0] pick_lightness(input bit want_dark);
    int unsigned lim;
    lim = (32'(thr_reg) > 256) ? 256 : 32'(thr_reg);
    if (want_dark && lim != 0) return drtps_pkg::PIX_W'($urandom_range(0, lim - 1));
    if (!want_dark && lim <= 255) return drtps_pkg::PIX_W'($urandom_range(lim, 255));
    return drtps_pkg::PIX_W'($urandom_range(0, 255));
  endfunction

  task automatic add_cfg(input drtps_pkg::cfg_idx_t idx, input int unsigned data);
    stim_row_t r;
    r.kind = ROW_CFG;
    r.idx = idx;
    r.data = drtps_pkg::CFG_DATA_W'(data);
    r.lightness = '0;
    r.typed = 0;
    r.n = 0;
    dir_rows.push_back(r);
  endtask

  task automatic add_typed(input logic [drtps_pkg::PIX_W-1:0] l, input int n,
                           input stroke_pt_t p0, input stroke_pt_t p1, input stroke_pt_t p2);
    stim_row_t r;
    r.kind = ROW_PIXEL;
    r.idx = drtps_pkg::CFG_IMAGE_WIDTH;
    r.data = '0;
    r.lightness = l;
    r.typed = 1;
    r.n = n;
    r.pts[0] = p0;
    r.pts[1] = p1;
    r.pts[2] = p2;
    dir_rows.push_back(r);
  endtask

  task automatic add_pixel(input logic [drtps_pkg::PIX_W-1:0] l);
    add_typed(l, 0, NO_PT, NO_PT, NO_PT);
    dir_rows[dir_rows.size()-1].typed = 0;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_points.size() != 0);
    repeat (SETTLE) @(negedge clk);
    quiet = 1;
  endtask

  task automatic write_reg(input drtps_pkg::cfg_idx_t idx, input int unsigned data);
    logic [drtps_pkg::CFG_DATA_W-1:0] d;
    d = drtps_pkg::CFG_DATA_W'(data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    case (idx)
      drtps_pkg::CFG_IMAGE_WIDTH:    img_w_reg = d[drtps_pkg::DIM_W-1:0];
      drtps_pkg::CFG_IMAGE_HEIGHT:   img_h_reg = d[drtps_pkg::DIM_W-1:0];
      drtps_pkg::CFG_PAGE_WIDTH:     page_w_reg = d[drtps_pkg::PAGE_W-1:0];
      drtps_pkg::CFG_PAGE_HEIGHT:    page_h_reg = d[drtps_pkg::PAGE_W-1:0];
      drtps_pkg::CFG_DARK_THRESHOLD: thr_reg = d[drtps_pkg::THR_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic program_regs(input int unsigned w, input int unsigned h, input int unsigned pw,
                              input int unsigned ph, input int unsigned thr);
    write_reg(drtps_pkg::CFG_IMAGE_WIDTH, w);
    write_reg(drtps_pkg::CFG_IMAGE_HEIGHT, h);
    write_reg(drtps_pkg::CFG_PAGE_WIDTH, pw);
    write_reg(drtps_pkg::CFG_PAGE_HEIGHT, ph);
    write_reg(drtps_pkg::CFG_DARK_THRESHOLD, thr);
  endtask

  task automatic send_pixel(input stim_row_t r);
    int gap;
    int i;
    gap = draw_gap(send_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_lightness <= r.lightness;
    do @(posedge clk); while (!in_ready);
    if (r.typed) begin
      plot_pixel(r.lightness, 0);
      for (i = 0; i < r.n; i++) pending_points.push_back(r.pts[i]);
    end else begin
      plot_pixel(r.lightness, 1);
    end
    quiet = 0;
    @(negedge clk);
  endtask

  // receiver
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else if (recv_wait > 0) begin
        out_ready <= 1'b0;
        recv_wait--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    stroke_pt_t want;
    if (rst_n && out_valid && out_ready) begin
      recv_wait = draw_gap(recv_calm);
      if (pending_points.size() == 0) begin
        report_mismatch($sformatf("unexpected word cmd=%0d x=%0d y=%0d last=%0d",
                                  out_command, out_pos_x, out_pos_y, out_last));
      end else begin
        want = pending_points.pop_front();
        if (out_command !== want.cmd)
          report_mismatch($sformatf("command got %0d want %0d", out_command, want.cmd));
        if (out_pos_x !== want.x)
          report_mismatch($sformatf("pos_x got %0d want %0d", out_pos_x, want.x));
        if (out_pos_y !== want.y)
          report_mismatch($sformatf("pos_y got %0d want %0d", out_pos_y, want.y));
        if (out_last !== want.last)
          report_mismatch($sformatf("last got %0d want %0d", out_last, want.last));
      end
    end
  end

  initial begin
    stim_row_t r;
    int        k;
    int        ph;
    int        i;
    bit        dark_tone;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_lightness = '0;
    cfg_we = 1'b0;
    cfg_index = drtps_pkg::CFG_IMAGE_WIDTH;
    cfg_data = '0;
    img_w_reg = drtps_pkg::RST_IMAGE_WIDTH;
    img_h_reg = drtps_pkg::RST_IMAGE_HEIGHT;
    page_w_reg = drtps_pkg::RST_PAGE_WIDTH;
    page_h_reg = drtps_pkg::RST_PAGE_HEIGHT;
    thr_reg = drtps_pkg::RST_DARK_THRESHOLD;
    cur_col = 0;
    cur_row = 0;
    in_stroke = 0;
    dark_tone = 0;

    // reset values: 256x256 image, 950x1485 page, threshold 127
    add_typed(8'd0, 1, pt(drtps_pkg::CMD_PEN_DOWN, 0, 0, 1'b1), NO_PT, NO_PT);
    add_typed(8'd126, 0, NO_PT, NO_PT, NO_PT);
    add_typed(8'd127, 1, pt(drtps_pkg::CMD_PEN_UP, 7, 0, 1'b1), NO_PT, NO_PT);
    add_typed(8'd255, 0, NO_PT, NO_PT, NO_PT);
    // zero dimensions act as one, everything dark
    add_cfg(drtps_pkg::CFG_IMAGE_WIDTH, 0);
    add_cfg(drtps_pkg::CFG_IMAGE_HEIGHT, 0);
    add_cfg(drtps_pkg::CFG_DARK_THRESHOLD, 256);
    add_typed(8'd255, 3, pt(drtps_pkg::CMD_PEN_DOWN, 0, 0, 1'b0),
              pt(drtps_pkg::CMD_PEN_UP, 950, 0, 1'b0), pt(drtps_pkg::CMD_PEN_UP, 0, 0, 1'b1));
    add_cfg(drtps_pkg::CFG_DARK_THRESHOLD, 0);
    add_typed(8'd0, 1, pt(drtps_pkg::CMD_PEN_UP, 0, 0, 1'b1), NO_PT, NO_PT);
    // writes past the register list change nothing
    add_cfg(CFG_SPARE_5, 16'hFFFF);
    add_cfg(CFG_SPARE_6, 16'h0001);
    add_cfg(CFG_SPARE_7, 16'h0000);
    add_typed(8'd0, 1, pt(drtps_pkg::CMD_PEN_UP, 0, 0, 1'b1), NO_PT, NO_PT);
    // oversized dimensions clamp, full-scale page
    add_cfg(drtps_pkg::CFG_IMAGE_WIDTH, 16'hFFFF);
    add_cfg(drtps_pkg::CFG_IMAGE_HEIGHT, 4097);
    add_cfg(drtps_pkg::CFG_PAGE_WIDTH, 65535);
    add_cfg(drtps_pkg::CFG_PAGE_HEIGHT, 65535);
    add_cfg(drtps_pkg::CFG_DARK_THRESHOLD, 128);
    add_typed(8'd127, 1, pt(drtps_pkg::CMD_PEN_DOWN, 0, 0, 1'b1), NO_PT, NO_PT);
    add_typed(8'd128, 1, pt(drtps_pkg::CMD_PEN_UP, 15, 0, 1'b1), NO_PT, NO_PT);
    add_typed(8'd0, 1, pt(drtps_pkg::CMD_PEN_DOWN, 31, 0, 1'b1), NO_PT, NO_PT);
    // shrink mid-image: counters clamp to the last index
    add_cfg(drtps_pkg::CFG_IMAGE_WIDTH, 2);
    add_typed(8'd5, 1, pt(drtps_pkg::CMD_PEN_UP, 65535, 0, 1'b1), NO_PT, NO_PT);
    add_cfg(drtps_pkg::CFG_IMAGE_HEIGHT, 2);
    add_typed(8'd255, 0, NO_PT, NO_PT, NO_PT);
    add_typed(8'd0, 3, pt(drtps_pkg::CMD_PEN_DOWN, 32767, 32767, 1'b0),
              pt(drtps_pkg::CMD_PEN_UP, 65535, 32767, 1'b0),
              pt(drtps_pkg::CMD_PEN_UP, 0, 0, 1'b1));
    add_cfg(drtps_pkg::CFG_IMAGE_WIDTH, 3);
    add_cfg(drtps_pkg::CFG_IMAGE_HEIGHT, 3);
    add_cfg(drtps_pkg::CFG_PAGE_WIDTH, 950);
    add_cfg(drtps_pkg::CFG_PAGE_HEIGHT, 1485);
    add_cfg(drtps_pkg::CFG_DARK_THRESHOLD, 127);
    add_pixel(8'd0);
    add_pixel(8'd255);
    add_pixel(8'd0);
    add_pixel(8'd0);
    add_pixel(8'd128);
    add_pixel(8'd200);
    add_pixel(8'd1);
    add_pixel(8'd254);
    add_pixel(8'd0);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (k = 0; k < dir_rows.size(); k++) begin
      if (dir_rows[k].kind == ROW_CFG) begin
        if (!quiet) wait_drained();
        write_reg(dir_rows[k].idx, 32'(dir_rows[k].data));
      end else begin
        send_pixel(dir_rows[k]);
      end
    end

    for (ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      case (ph)
        0: program_regs(4, 3, 8400, 11880, 127);
        1: program_regs(1, 2, 950, 1485, 200);
        2: program_regs(7, 5, 65535, 65535, 256);
        3: program_regs(3, 1, 1, 1, 0);
        default: begin
          program_regs(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                   : $urandom_range(0, 9),
                       $urandom_range(0, 6), $urandom_range(1, 65535),
                       $urandom_range(1, 65535), $urandom_range(0, 256));
          write_reg(drtps_pkg::cfg_idx_t'($urandom_range(5, 7)), $urandom_range(0, 65535));
        end
      endcase
      // receiver stalls long while one-pixel rows keep the queue full
      if (ph == 1) hold_req = 1;
      for (i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(0, 2) == 0) dark_tone = !dark_tone;
        r.kind = ROW_PIXEL;
        r.idx = drtps_pkg::CFG_IMAGE_WIDTH;
        r.data = '0;
        r.typed = 0;
        r.n = 0;
        r.lightness = ($urandom_range(0, 7) == 0) ? drtps_pkg::PIX_W'($urandom_range(0, 255))
                                                  : pick_lightness(dark_tone);
        send_pixel(r);
        if ($urandom_range(0, 39) == 0) wait_drained();
      end
    end

    wait_drained();
    if (mismatches == 0) begin
      $display("PASS dark_run_to_plotter_strokes");
    end else begin
      $display("FAIL dark_run_to_plotter_strokes");
    end
    $finish;
  end

endmodule
